[rtl/mpv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpv_pkg: shared types and SHA-256 helpers
// Round constants, initial state, round functions and the request type
// passed between the front end and the hash engine.
// ----------------------------------------------------------------------------
package mpv_pkg;

   localparam int DIGEST_BITS = 256;
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROOT_0 = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROOT_1 = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROOT_2 = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROOT_3 = 2'd3;

   localparam logic KIND_LEAF = 1'b0;
   localparam logic KIND_SIBLING = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [DIGEST_BITS-1:0] digest;
      logic [63:0]            index;
      logic                   final_item;
   } mpv_req_type;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [511:0] PAD_BLOCK = {32'h80000000, 448'd0, 32'd512};

   function automatic logic [31:0] sha_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one compression round on the packed a..h state
   function automatic logic [255:0] sha_round(input logic [255:0] s,
                                              input logic [31:0] kw);
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      {a, b, c, d, e, f, g, h} = s;
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + kw;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      return {t1 + t2, a, b, c, d + t1, e, f, g};
   endfunction

   // next schedule word from the 16-word window (w[0] oldest, at the top)
   function automatic logic [31:0] sha_sched(input logic [511:0] w);
      logic [31:0] w0, w1, w9, w14, s0, s1;
      w0 = w[511:480];
      w1 = w[479:448];
      w9 = w[223:192];
      w14 = w[63:32];
      s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      return w0 + s0 + w9 + s1;
   endfunction

   function automatic logic [255:0] add_words(input logic [255:0] x, input logic [255:0] y);
      logic [255:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i*32 +: 32] = x[i*32 +: 32] + y[i*32 +: 32];
      end
      return r;
   endfunction

endpackage

[rtl/mpv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpv_front: request intake
// Registers an accepted request into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module mpv_front #(
   parameter int INDEX_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [255:0]              req_digest,
   input  logic [31:0]               req_leaf_index,
   input  logic                      req_final_item,
   output logic                      q_valid,
   input  logic                      q_ready,
   output mpv_pkg::mpv_req_type      q_req
);
   import mpv_pkg::*;

   mpv_req_type slot_ff [2];
   mpv_req_type slot_in;
   logic [1:0]  count_ff, count_in;
   logic        rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic        push, pop;
   logic [63:0] idx_ext;

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign q_valid = (count_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_req = slot_ff[rd_ptr_ff];

   always_comb begin
      idx_ext = '0;
      // keep only the low INDEX_BITS of the leaf position
      for (int i = 0; i < INDEX_BITS && i < 32; i++) begin
         idx_ext[i] = req_leaf_index[i];
      end
      slot_in.kind = req_kind;
      slot_in.digest = req_digest;
      slot_in.index = idx_ext;
      slot_in.final_item = req_final_item;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

[rtl/mpv_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpv_engine: path hash engine
// Holds the running digest and index, runs two SHA-256 compressions per
// sibling one round per cycle, and compares against the root on the last
// request.
// ----------------------------------------------------------------------------
module mpv_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  mpv_pkg::mpv_req_type q_req,
   input  logic [255:0]         root,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_root_matches
);
   import mpv_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RUN1 = 3'd1;
   localparam logic [2:0] ST_RUN2 = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [255:0] digest_ff, digest_in;
   logic [63:0]  index_ff, index_in;
   logic [255:0] work_ff, work_in;
   logic [255:0] mid_ff, mid_in;
   logic [511:0] sched_ff, sched_in;
   logic [5:0]   round_ff, round_in;
   logic         final_ff, final_in;
   logic         match_ff, match_in;
   logic [31:0]  kw;
   logic [255:0] rnd;
   logic [255:0] sum;

   assign q_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_root_matches = match_ff;
   assign kw = sha_k(round_ff) + sched_ff[511:480];
   assign rnd = sha_round(work_ff, kw);
   assign sum = add_words(mid_ff, rnd);

   always_comb begin
      state_in = state_ff;
      digest_in = digest_ff;
      index_in = index_ff;
      work_in = work_ff;
      mid_in = mid_ff;
      sched_in = sched_ff;
      round_in = round_ff;
      final_in = final_ff;
      match_in = match_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               final_in = q_req.final_item;
               if (q_req.kind == KIND_LEAF) begin
                  digest_in = q_req.digest;
                  index_in = q_req.index;
                  state_in = q_req.final_item ? ST_CMP : ST_IDLE;
               end else begin
                  sched_in = index_ff[0] ? {q_req.digest, digest_ff}
                                         : {digest_ff, q_req.digest};
                  index_in = index_ff >> 1;
                  work_in = SHA_IV;
                  mid_in = SHA_IV;
                  round_in = '0;
                  state_in = ST_RUN1;
               end
            end
         end
         ST_RUN1, ST_RUN2: begin
            work_in = rnd;
            sched_in = {sched_ff[479:0], sha_sched(sched_ff)};
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               if (state_ff == ST_RUN1) begin
                  mid_in = sum;
                  work_in = sum;
                  sched_in = PAD_BLOCK;
                  state_in = ST_RUN2;
               end else begin
                  digest_in = sum;
                  state_in = final_ff ? ST_CMP : ST_IDLE;
               end
            end
         end
         ST_CMP: begin
            match_in = (digest_ff == root);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         digest_ff <= '0;
         index_ff <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         digest_ff <= digest_in;
         index_ff <= index_in;
         round_ff <= round_in;
         final_ff <= final_in;
      end
      work_ff <= work_in;
      mid_ff <= mid_in;
      sched_ff <= sched_in;
      match_ff <= match_in;
   end

endmodule

[rtl/merkle_path_verifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merkle_path_verifier: SHA-256 Merkle authentication path check
// Walks a leaf digest up a path of sibling digests and reports whether the
// result equals the configured root.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    kind, hash_word_0..3, leaf_index, final_item
// rsp      out        rsp_valid/rsp_ready    root_matches
// csr      in         csr_valid/csr_ready    csr_index, csr_data (root_word_0..3)
//
// In the engine a sibling is taken in and then runs two 64-round compressions at
// one round per cycle; a leaf is only taken in. A final request then passes
// through a compare state and holds its response until taken.
// Synchronous reset clears the queue, the running digest and index and the
// root. A two-entry queue lets requests arrive while the engine is busy.
module merkle_path_verifier #(
   parameter int INDEX_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [63:0] req_hash_word_0,
   input  logic [63:0] req_hash_word_1,
   input  logic [63:0] req_hash_word_2,
   input  logic [63:0] req_hash_word_3,
   input  logic [31:0] req_leaf_index,
   input  logic        req_final_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_root_matches,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import mpv_pkg::*;

   logic [63:0] root_ff [4];
   logic        q_valid, q_ready;
   mpv_req_type q_req;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            root_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROOT_0: root_ff[0] <= csr_data;
            CSR_ROOT_1: root_ff[1] <= csr_data;
            CSR_ROOT_2: root_ff[2] <= csr_data;
            CSR_ROOT_3: root_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   mpv_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_digest     ({req_hash_word_0, req_hash_word_1, req_hash_word_2, req_hash_word_3}),
      .req_leaf_index (req_leaf_index),
      .req_final_item (req_final_item),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_req          (q_req)
   );

   mpv_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_req            (q_req),
      .root             ({root_ff[0], root_ff[1], root_ff[2], root_ff[3]}),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_root_matches (rsp_root_matches)
   );

endmodule

[test/merkle_path_verifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merkle_path_verifier_tb: self-checking bench for the Merkle path verifier
// Drives leaf and sibling requests through a directed table and then
// random proofs, predicts each root match with a local SHA-256 path walk
// or from the table, and compares every response in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module merkle_path_verifier_tb;
   import mpv_pkg::*;

   typedef struct packed {
      logic         kind;
      logic [255:0] digest;
      logic [31:0]  index;
      logic         final_item;
      logic         typed;
      logic         hit;
   } path_req_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 600;
   localparam int TARGET_REQS = 1250;
   localparam logic [255:0] ONES = {256{1'b1}};
   localparam logic [255:0] PAT_A =
      256'h0123456789abcdef_fedcba9876543210_a5a5a5a55a5a5a5a_0f1e2d3c4b5a6978;
   localparam logic [255:0] PAT_B =
      256'h8000000000000001_7fffffffffffffff_deadbeefcafef00d_1122334455667788;

   localparam path_req_type DIRECTED [16] = '{
      '{KIND_SIBLING, 256'd0, 32'd0, 1'b1, 1'b0, 1'b0},
      '{KIND_LEAF, 256'd0, 32'd0, 1'b1, 1'b1, 1'b1},
      '{KIND_LEAF, ONES, 32'hffffffff, 1'b1, 1'b1, 1'b0},
      '{KIND_LEAF, ONES, 32'hffffffff, 1'b0, 1'b0, 1'b0},
      '{KIND_SIBLING, 256'd0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{KIND_SIBLING, ONES, 32'hffffffff, 1'b1, 1'b0, 1'b0},
      '{KIND_LEAF, PAT_A, 32'd0, 1'b0, 1'b0, 1'b0},
      '{KIND_SIBLING, PAT_B, 32'd0, 1'b0, 1'b0, 1'b0},
      '{KIND_SIBLING, PAT_A, 32'd0, 1'b1, 1'b0, 1'b0},
      '{KIND_LEAF, PAT_B, 32'd5, 1'b0, 1'b0, 1'b0},
      '{KIND_SIBLING, PAT_A, 32'd0, 1'b0, 1'b0, 1'b0},
      '{KIND_SIBLING, ONES, 32'd0, 1'b0, 1'b0, 1'b0},
      '{KIND_SIBLING, 256'd0, 32'd0, 1'b1, 1'b0, 1'b0},
      '{KIND_LEAF, PAT_A, 32'h80000000, 1'b0, 1'b0, 1'b0},
      '{KIND_LEAF, 256'd0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{KIND_LEAF, 256'd0, 32'd0, 1'b1, 1'b1, 1'b1}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [63:0] req_hash_word_0 = '0;
   logic [63:0] req_hash_word_1 = '0;
   logic [63:0] req_hash_word_2 = '0;
   logic [63:0] req_hash_word_3 = '0;
   logic [31:0] req_leaf_index = '0;
   logic        req_final_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_root_matches;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [255:0] model_root;
   logic [255:0] model_digest;
   logic [31:0]  model_index;
   bit           match_q[$];
   path_req_type proof_q[$];
   int           cyc;
   int           quiet_cycles;
   int           sent;
   int           errors;
   bit           quiet;

   merkle_path_verifier uut (.*);

   always #5 clock = ~clock;

   assign quiet = (cyc >= 60000 && cyc < 90000);

   // ---------------------------------------------------------------- SHA-256
   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [255:0] compress_block(input logic [255:0] st,
                                                   input logic [511:0] blk);
      logic [31:0] w [64];
      logic [31:0] k [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      logic [255:0] res;
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = st[255 - 32*i -: 32];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = st[255 - 32*i -: 32] + v[i];
      return res;
   endfunction

   function automatic logic [255:0] node_digest(input logic [255:0] left,
                                                input logic [255:0] right);
      logic [255:0] st;
      st = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      st = compress_block(st, {left, right});
      return compress_block(st, {32'h80000000, 448'd0, 32'd512});
   endfunction

   // advance one request through a path state
   function automatic void walk_step(input path_req_type r, inout logic [255:0] dig,
                                     inout logic [31:0] idx);
      if (r.kind == KIND_LEAF) begin
         dig = r.digest;
         idx = r.index;
      end else begin
         dig = idx[0] ? node_digest(r.digest, dig) : node_digest(dig, r.digest);
         idx = idx >> 1;
      end
   endfunction

   function automatic logic [255:0] proof_root();
      logic [255:0] dig;
      logic [31:0]  idx;
      dig = model_digest;
      idx = model_index;
      foreach (proof_q[i]) walk_step(proof_q[i], dig, idx);
      return dig;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_req(input path_req_type r);
      if (!quiet && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (!quiet && $urandom_range(0, 99) < 16) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_hash_word_0 <= r.digest[255:192];
      req_hash_word_1 <= r.digest[191:128];
      req_hash_word_2 <= r.digest[127:64];
      req_hash_word_3 <= r.digest[63:0];
      req_leaf_index <= r.index;
      req_final_item <= r.final_item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      walk_step(r, model_digest, model_index);
      if (r.final_item)
         match_q.insert(match_q.size(), r.typed ? r.hit : (model_digest == model_root));
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (match_q.size() != 0) @(posedge clock);
      // a few non-final siblings may still be hashing
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_root(input logic [255:0] root);
      logic [1:0] regs [4];
      regs = '{CSR_ROOT_0, CSR_ROOT_1, CSR_ROOT_2, CSR_ROOT_3};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data <= root[255 - 64*i -: 64];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      model_root = root;
   endtask

   function automatic logic [255:0] rand_digest();
      logic [255:0] d;
      for (int i = 0; i < 8; i++) d[32*i +: 32] = $urandom;
      return d;
   endfunction

   function automatic void build_proof();
      int depth;
      path_req_type r;
      depth = ($urandom_range(0, 99) < 5) ? 33 + $urandom_range(0, 2) : $urandom_range(1, 6);
      proof_q.delete();
      r = '0;
      r.kind = KIND_LEAF;
      r.digest = rand_digest();
      case ($urandom_range(0, 5))
         0: r.index = '0;
         1: r.index = '1;
         default: r.index = $urandom;
      endcase
      proof_q.insert(proof_q.size(), r);
      for (int i = 0; i < depth; i++) begin
         r = '0;
         r.kind = KIND_SIBLING;
         r.digest = rand_digest();
         r.index = $urandom;
         proof_q.insert(proof_q.size(), r);
      end
      proof_q[depth].final_item = 1'b1;
   endfunction

   task automatic send_proof();
      foreach (proof_q[i]) send_req(proof_q[i]);
   endtask

   // ------------------------------------------------------- response checker
   always @(posedge clock) begin
      cyc <= cyc + 1;
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 16);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t timeout, %0d responses outstanding", $time, match_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (match_q.size() == 0) begin
            $display("%0t unexpected response root_matches=%0b", $time, rsp_root_matches);
            errors++;
         end else begin
            if (rsp_root_matches !== match_q[0]) begin
               $display("%0t root_matches mismatch: expected %0b actual %0b",
                        $time, match_q[0], rsp_root_matches);
               errors++;
            end
            void'(match_q.pop_front());
         end
      end
   end

   // --------------------------------------------------------------- stimulus
   initial begin
      logic [255:0] good_root;
      path_req_type r;
      int           pick;
      sent = 0;
      errors = 0;
      model_root = '0;
      model_digest = '0;
      model_index = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) send_req(DIRECTED[i]);
      drain();

      while (sent < TARGET_REQS) begin
         build_proof();
         good_root = proof_root();
         case ($urandom_range(0, 9))
            0: write_root('0);
            1: write_root(ONES);
            2: write_root(rand_digest());
            default: write_root(good_root);
         endcase
         send_proof();
         for (int n = 0; n < 3; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               send_proof();
            end else if (pick < 6) begin
               // flip one bit of each request of the same proof with probability 1/size
               foreach (proof_q[i]) begin
                  r = proof_q[i];
                  if ($urandom_range(0, proof_q.size() - 1) == 0)
                     r.digest[8'($urandom_range(0, 255))] ^= 1'b1;
                  send_req(r);
               end
            end else if (pick < 8) begin
               build_proof();
               send_proof();
            end else begin
               r = '0;
               r.kind = 1'($urandom_range(0, 1));
               r.digest = ($urandom_range(0, 3) == 0) ? good_root : rand_digest();
               r.index = $urandom;
               r.final_item = 1'($urandom_range(0, 1));
               send_req(r);
            end
         end
         drain();
      end

      drain();
      if (errors == 0 && match_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/mpv_pkg.sv
rtl/mpv_front.sv
rtl/mpv_engine.sv
rtl/merkle_path_verifier.sv
test/merkle_path_verifier_tb.sv
